// ===== src/ckb_pkg.sv =====
// ---------------------------------------------------------------------------
// ckb_pkg
// shared types, constants and helpers of the canonical k-mer bucketer
// ---------------------------------------------------------------------------
package ckb_pkg;

    localparam int MAX_K        = 32;
    localparam int BUCKET_LIMIT = 65536;

    localparam int KLEN_W  = 6;
    localparam int KMER_W  = 2 * MAX_K;
    localparam int DIV_W   = 64;
    localparam int BKT_W   = $clog2(BUCKET_LIMIT);
    localparam int BASE_W  = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int STEP_W  = $clog2(BKT_W);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_DIVISOR = CFG_IDX_W'(1);

    localparam logic [KLEN_W-1:0] KMER_LENGTH_RESET    = KLEN_W'(21);
    localparam logic [DIV_W-1:0]  BUCKET_DIVISOR_RESET = DIV_W'(1);

    localparam logic [BASE_W-1:0] BASE_MAX  = BASE_W'(3);
    localparam logic [BKT_W-1:0]  BKT_SAT   = BKT_W'(BUCKET_LIMIT - 1);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // queue handshake between front and back
    typedef struct packed {
        logic              valid;
        logic [KMER_W-1:0] data;
    } kmer_word_t;

    // length register mapped into 1..MAX_K
    function automatic logic [KLEN_W-1:0] eff_k(input logic [KLEN_W-1:0] len);
        logic [KLEN_W-1:0] k;
        k = len;
        if (k == '0) begin
            k = KLEN_W'(1);
        end
        if (k > KLEN_W'(MAX_K)) begin
            k = KLEN_W'(MAX_K);
        end
        return k;
    endfunction

    // two ones per base below k
    function automatic logic [KMER_W-1:0] window_mask(input logic [KLEN_W-1:0] k);
        logic [KMER_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_K; i++) begin
            if (KLEN_W'(i) < k) begin
                m[2*i +: 2] = 2'b11;
            end
        end
        return m;
    endfunction

endpackage

// ===== src/ckb_front.sv =====
// ---------------------------------------------------------------------------
// ckb_front
// rolling forward / reverse-complement windows, decides which bases emit
// ---------------------------------------------------------------------------
module ckb_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ckb_pkg::KLEN_W-1:0]    kmer_length,
    input  logic                          window_clear,
    input  logic                          in_take,
    input  logic [ckb_pkg::BASE_W-1:0]    base_code,
    input  logic                          seq_start,
    output ckb_pkg::kmer_word_t           push_word
);
    import ckb_pkg::*;

    logic [KMER_W-1:0] fwd_reg, fwd_next;
    logic [KMER_W-1:0] rev_reg, rev_next;
    logic [KLEN_W-1:0] fill_reg, fill_next;

    logic [KLEN_W-1:0] k_eff;
    logic [KLEN_W-1:0] k_m1;
    logic [KMER_W-1:0] mask;
    logic [KMER_W-1:0] fwd_base, rev_base;
    logic [KLEN_W-1:0] fill_base;
    logic [KMER_W-1:0] fwd_upd, rev_upd;
    logic [KLEN_W-1:0] fill_upd;

    always_comb begin
        k_eff = eff_k(kmer_length);
        k_m1  = k_eff - KLEN_W'(1);
        mask  = window_mask(k_eff);

        // a new sequence starts from empty windows
        fwd_base  = seq_start ? '0 : fwd_reg;
        rev_base  = seq_start ? '0 : rev_reg;
        fill_base = seq_start ? '0 : fill_reg;

        fwd_upd = ((fwd_base >> 2)
                  | (KMER_W'(base_code) << {k_m1[KLEN_W-2:0], 1'b0})) & mask;
        rev_upd = ((rev_base << 2) | KMER_W'(BASE_MAX - base_code)) & mask;
        fill_upd = (fill_base < k_eff) ? fill_base + KLEN_W'(1) : fill_base;

        fwd_next  = fwd_reg;
        rev_next  = rev_reg;
        fill_next = fill_reg;
        if (window_clear) begin
            fwd_next  = '0;
            rev_next  = '0;
            fill_next = '0;
        end else if (in_take) begin
            fwd_next  = fwd_upd;
            rev_next  = rev_upd;
            fill_next = fill_upd;
        end

        push_word.valid = in_take && !window_clear && (fill_upd >= k_eff);
        push_word.data  = (fwd_upd < rev_upd) ? fwd_upd : rev_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg  <= '0;
            rev_reg  <= '0;
            fill_reg <= '0;
        end else begin
            fwd_reg  <= fwd_next;
            rev_reg  <= rev_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== src/ckb_queue.sv =====
// ---------------------------------------------------------------------------
// ckb_queue
// small fifo of canonical values between front and back
// ---------------------------------------------------------------------------
module ckb_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ckb_pkg::kmer_word_t           push_word,
    output logic                          full,
    output ckb_pkg::kmer_word_t           head_word,
    input  logic                          pop
);
    import ckb_pkg::*;

    logic [KMER_W-1:0]  mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    always_comb begin
        do_push = push_word.valid && (count_reg != Q_CNT_W'(Q_DEPTH));
        do_pop  = pop && (count_reg != '0);

        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end

        full            = (count_reg == Q_CNT_W'(Q_DEPTH));
        head_word.valid = (count_reg != '0);
        head_word.data  = mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_word.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/ckb_back.sv =====
// ---------------------------------------------------------------------------
// ckb_back
// saturating bucket divider, one quotient bit a cycle, and output register
// ---------------------------------------------------------------------------
module ckb_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ckb_pkg::DIV_W-1:0]     bucket_divisor,
    input  ckb_pkg::kmer_word_t           head_word,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [79:0]                   m_tdata
);
    import ckb_pkg::*;

    back_state_t        state_reg, state_next;
    logic [KMER_W-1:0]  canon_reg, canon_next;
    logic [DIV_W:0]     rem_reg, rem_next;
    logic [BKT_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic [KMER_W-1:0]  out_kmer_reg, out_kmer_next;
    logic [BKT_W-1:0]   out_bkt_reg, out_bkt_next;

    logic [BKT_W-1:0]   canon_low;
    logic [DIV_W:0]     rem_shift;
    logic               q_bit;
    logic               saturate;
    logic               out_free;

    always_comb begin
        canon_low = canon_reg[BKT_W-1:0];
        rem_shift = {rem_reg[DIV_W-1:0], canon_low[step_reg]};
        q_bit     = (rem_shift >= {1'b0, bucket_divisor});
        // quotient does not fit when the divisor is zero or the top bits alone reach it
        saturate  = (bucket_divisor == '0)
                 || (DIV_W'(head_word.data[KMER_W-1:BKT_W]) >= bucket_divisor);
        out_free  = !out_valid_reg || m_tready;

        state_next     = state_reg;
        canon_next     = canon_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_kmer_next  = out_kmer_reg;
        out_bkt_next   = out_bkt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop            = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (head_word.valid) begin
                    pop        = 1'b1;
                    canon_next = head_word.data;
                    rem_next   = (DIV_W + 1)'(head_word.data[KMER_W-1:BKT_W]);
                    quo_next   = '0;
                    step_next  = STEP_W'(BKT_W - 1);
                    if (saturate) begin
                        quo_next   = BKT_SAT;
                        state_next = BK_DONE;
                    end else begin
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV: begin
                rem_next  = q_bit ? rem_shift - {1'b0, bucket_divisor} : rem_shift;
                quo_next  = {quo_reg[BKT_W-2:0], q_bit};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kmer_next  = canon_reg;
                    out_bkt_next   = quo_reg;
                    state_next     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        m_tvalid = out_valid_reg;
        m_tdata  = {out_bkt_reg, out_kmer_reg};
    end

    always_ff @(posedge aclk) begin
        canon_reg    <= canon_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        out_kmer_reg <= out_kmer_next;
        out_bkt_reg  <= out_bkt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/canonical_kmer_bucketer.sv =====
// ---------------------------------------------------------------------------
// canonical_kmer_bucketer
// canonical 2-bit k-mer value of a base stream with a saturated bucket index
// ---------------------------------------------------------------------------
// usage:
//   s_ channel takes one base word per handshake: s_tdata[1:0] is the base
//   code, s_tuser marks the first base of a new sequence. the front keeps a
//   forward and a reverse-complement window and takes a base in every cycle
//   while its four-entry queue has room.
//   once k bases of the sequence are held, each base produces one m_ word:
//   m_tdata[63:0] canonical k-mer, m_tdata[79:64] bucket index.
//   the back divides by the bucket divisor one quotient bit per cycle.
//   it loads a value from the queue, divides it and, once the output
//   register is free, hands the result on; a saturated bucket (quotient
//   too big, or divisor zero) skips the division. the back takes no new
//   value until its result is handed on, so values wait in the queue.
//   when m_tready stays low, the result holds in the output register, the
//   divider finishes the next value, then the queue fills and s_tready drops.
//   cfg channel, always ready: index 0 kmer_length (clears the windows),
//   1 bucket_divisor. write only while idle; the block does not enforce it.
//   reset (aresetn low, synchronous) empties windows, queue and output and
//   loads kmer_length 21, bucket_divisor 1.
// ---------------------------------------------------------------------------
module canonical_kmer_bucketer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [1:0] base_code, rest zero
    input  logic                              s_tuser,   // [0] seq_start
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [79:0]                       m_tdata,   // [63:0] canonical_kmer,
                                                         // [79:64] bucket_index
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ckb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ckb_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import ckb_pkg::*;

    logic [KLEN_W-1:0] kmer_length_reg, kmer_length_next;
    logic [DIV_W-1:0]  divisor_reg, divisor_next;

    logic       cfg_wr;
    logic       kmer_wr;
    logic       q_full;
    logic       in_take;
    logic       q_pop;
    kmer_word_t push_word;
    kmer_word_t head_word;

    // config registers
    always_comb begin
        cfg_ready        = 1'b1;
        cfg_wr           = cfg_valid && cfg_ready;
        kmer_wr          = 1'b0;
        kmer_length_next = kmer_length_reg;
        divisor_next     = divisor_reg;
        if (cfg_wr) begin
            unique case (cfg_index)
                CFG_KMER_LENGTH: begin
                    kmer_wr          = 1'b1;
                    kmer_length_next = cfg_data[KLEN_W-1:0];
                end
                CFG_BUCKET_DIVISOR: begin
                    divisor_next = cfg_data[DIV_W-1:0];
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg <= KMER_LENGTH_RESET;
            divisor_reg     <= BUCKET_DIVISOR_RESET;
        end else begin
            kmer_length_reg <= kmer_length_next;
            divisor_reg     <= divisor_next;
        end
    end

    // front takes a base whenever the queue can hold a result
    assign s_tready = !q_full;
    assign in_take  = s_tvalid && s_tready;

    ckb_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .kmer_length  (kmer_length_reg),
        .window_clear (kmer_wr),
        .in_take      (in_take),
        .base_code    (s_tdata[BASE_W-1:0]),
        .seq_start    (s_tuser),
        .push_word    (push_word)
    );

    ckb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_word (push_word),
        .full      (q_full),
        .head_word (head_word),
        .pop       (q_pop)
    );

    ckb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .bucket_divisor (divisor_reg),
        .head_word      (head_word),
        .pop            (q_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

    // a zero divisor always lands in the top bucket
    a_div_zero_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (divisor_reg == '0)) |-> (m_tdata[79:64] == BKT_SAT))
        else $error("zero divisor did not saturate bucket");

    // with a nonzero divisor an unsaturated quotient never exceeds the value
    a_quo_le_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (divisor_reg != '0) && (m_tdata[79:64] != BKT_SAT))
        |-> (KMER_W'(m_tdata[79:64]) <= m_tdata[63:0]))
        else $error("bucket index above canonical value");

    // divisor one maps small values onto themselves
    a_div_one_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (divisor_reg == DIV_W'(1)) && (m_tdata[63:0] < KMER_W'(BKT_SAT)))
        |-> (m_tdata[79:64] == m_tdata[BKT_W-1:0]))
        else $error("divisor one gave wrong bucket");

    // a result never rises directly after a queue pop
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!q_pop, 1))
        else $error("result raised directly after a queue pop");

endmodule
